// ----- rtl/lppd_pkg.sv -----
// Shared constants and types of the lidar packet point decoder.
package lppd_pkg;

  // Layout parameters
  localparam int CHANNELS     = 48;
  localparam int BLOCKS       = 8;
  localparam int PACKET_BYTES = 1248;

  // Field and counter widths
  localparam int OFF_W  = 11;
  localparam int POS_W  = 8;
  localparam int BLK_W  = 5;
  localparam int CH_W   = 6;
  localparam int ICH_W  = 7;
  localparam int ANG_W  = 17;
  localparam int SUM_W  = 20;
  localparam int TAB_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Byte offsets within a datagram
  localparam logic [OFF_W-1:0] OFF_MAX     = {OFF_W{1'b1}};
  localparam logic [OFF_W-1:0] SEC_OFF     = OFF_W'(20);
  localparam logic [OFF_W-1:0] MICRO_OFF   = OFF_W'(26);
  localparam logic [OFF_W-1:0] MICRO_END   = OFF_W'(30);
  localparam logic [OFF_W-1:0] HEADER_OFF  = OFF_W'(42);
  localparam logic [OFF_W-1:0] PACKET_LEN  = OFF_W'(PACKET_BYTES);
  localparam logic [OFF_W-1:0] INFO_MINLEN = OFF_W'(1044);
  localparam logic [OFF_W-1:0] VANG_OFF    = OFF_W'(468);

  // Block layout
  localparam logic [POS_W-1:0] POS_FLAG_HI = POS_W'(0);
  localparam logic [POS_W-1:0] POS_FLAG_LO = POS_W'(1);
  localparam logic [POS_W-1:0] POS_AZ_HI   = POS_W'(2);
  localparam logic [POS_W-1:0] POS_AZ_LO   = POS_W'(3);
  localparam logic [POS_W-1:0] POS_POINTS  = POS_W'(4);
  localparam logic [POS_W-1:0] POS_LAST    = POS_W'(4 + 3 * CHANNELS - 1);
  localparam logic [BLK_W-1:0] BLK_END     = BLK_W'(BLOCKS);
  localparam logic [CH_W-1:0]  CH_LAST     = CH_W'(CHANNELS - 1);
  localparam logic [ICH_W-1:0] ICH_LAST    = ICH_W'(CHANNELS - 1);
  localparam logic [ICH_W-1:0] ICH_END     = ICH_W'(CHANNELS);

  // Byte codes
  localparam logic [7:0] FLAG_HI_BYTE  = 8'hFF;
  localparam logic [7:0] FLAG_LO_BYTE  = 8'hEE;
  localparam logic [7:0] SIGN_NEG_BYTE = 8'h01;
  localparam logic [14:0] DIST_MASK    = 15'h7FFF;

  // Azimuth accumulation
  localparam logic signed [17:0] FULL_TURN = 18'sd36000;
  localparam logic [SUM_W-1:0]   TURN_SUM  = SUM_W'(36000);
  localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};

  // Three-byte groups: sign/high/low for angles, dist high/low/intensity for points
  typedef logic [1:0] part_t;
  localparam part_t PART_0 = 2'd0;
  localparam part_t PART_1 = 2'd1;
  localparam part_t PART_2 = 2'd2;

endpackage

// ----- rtl/lppd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module lppd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/lidar_packet_point_decoder_core.sv -----
// Byte-serial lidar datagram decoder: angle table load and point extraction.
//
//   channel | ports                       | moves
//   --------+-----------------------------+-------------------------------
//   in      | in_valid / in_ready         | one datagram byte per request
//   out     | out_valid / out_ready       | one decoded point per request
//
// One byte is taken every cycle while the output side keeps up. After its
// intensity byte, a point passes the read stage, where the angle table is read,
// and then the output register. The angle table is a RAM with registered
// read; it has no reset and is loaded by a device-info datagram. Reset clears
// all control state at once. When the output stalls, one point waits in the
// read stage and one in the output register before in_ready drops.
module lidar_packet_point_decoder_core import lppd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_func,
  input  logic [7:0]              in_pkt_byte,
  input  logic [OFF_W-1:0]        in_pkt_len,
  input  logic                    in_first_byte,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [15:0]             out_azimuth,
  output logic [CH_W-1:0]         out_channel,
  output logic [14:0]             out_distance_raw,
  output logic [7:0]              out_intensity,
  output logic signed [ANG_W-1:0] out_vertical_angle,
  output logic [47:0]             out_stamp_seconds,
  output logic [31:0]             out_stamp_micros,
  output logic                    out_frame_end
);

  typedef struct packed {
    logic [15:0]     azimuth;
    logic [CH_W-1:0] channel;
    logic [14:0]     distance;
    logic [7:0]      intensity;
    logic [47:0]     seconds;
    logic [31:0]     micros;
    logic            frame_end;
  } point_t;

  // Byte position tracking
  logic [OFF_W-1:0] off_r, off_nxt;
  logic [POS_W-1:0] d_pos_r, d_pos_nxt;
  logic [BLK_W-1:0] d_blk_r, d_blk_nxt;
  logic [CH_W-1:0]  d_ch_r, d_ch_nxt;
  part_t            d_part_r, d_part_nxt;
  logic [ICH_W-1:0] i_ch_r, i_ch_nxt;
  part_t            i_part_r, i_part_nxt;

  // Decoder state
  logic             accepted_r, accepted_nxt;
  logic             table_valid_r, table_valid_nxt;
  logic [7:0]       sign_hold_r, sign_hold_nxt;
  logic [7:0]       high_hold_r, high_hold_nxt;
  logic [47:0]      time_sec_r, time_sec_nxt;
  logic [31:0]      time_us_r, time_us_nxt;
  logic             flag_ok_r, flag_ok_nxt;
  logic [15:0]      block_az_r, block_az_nxt;
  logic [14:0]      dist_hold_r, dist_hold_nxt;
  logic             collecting_r, collecting_nxt;
  logic [SUM_W-1:0] angle_sum_r, angle_sum_nxt;
  logic [15:0]      prev_az_r, prev_az_nxt;

  // Read stage and output register
  logic             s1_valid_r, s1_valid_nxt;
  point_t           s1_pt_r;
  logic             out_valid_r, out_valid_nxt;
  point_t           out_pt_r;
  logic [ANG_W-1:0] out_angle_r;

  logic             accept, out_free, move, emit, len_ok, active;
  logic             dat_in, inf_in;
  logic             tab_we;
  logic [ANG_W-1:0] tab_wdata, tab_rdata;
  logic [15:0]      az_new;
  logic [15:0]      ang_mag;
  logic signed [17:0] delta;
  logic signed [21:0] sum_ext;
  point_t           pt_new;

  assign out_free = !out_valid_r || out_ready;
  assign move     = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;
  assign accept   = in_valid && in_ready;

  assign len_ok = in_func ? (in_pkt_len >= INFO_MINLEN) : (in_pkt_len == PACKET_LEN);

  // Offset and layout counters for the current byte
  always_comb begin
    if (in_first_byte) begin
      off_nxt = '0;
    end else if (off_r == OFF_MAX) begin
      off_nxt = OFF_MAX;
    end else begin
      off_nxt = off_r + OFF_W'(1);
    end

    if (off_nxt == HEADER_OFF || d_pos_r == POS_LAST) begin
      d_pos_nxt = '0;
    end else begin
      d_pos_nxt = d_pos_r + POS_W'(1);
    end

    if (off_nxt == HEADER_OFF) begin
      d_blk_nxt = '0;
    end else if (d_pos_r == POS_LAST && d_blk_r != BLK_END) begin
      d_blk_nxt = d_blk_r + BLK_W'(1);
    end else begin
      d_blk_nxt = d_blk_r;
    end

    if (off_nxt == HEADER_OFF || d_pos_nxt <= POS_POINTS) begin
      d_ch_nxt   = '0;
      d_part_nxt = PART_0;
    end else if (d_part_r == PART_2) begin
      d_ch_nxt   = d_ch_r + CH_W'(1);
      d_part_nxt = PART_0;
    end else begin
      d_ch_nxt   = d_ch_r;
      d_part_nxt = d_part_r + part_t'(1);
    end

    if (off_nxt == VANG_OFF) begin
      i_ch_nxt   = '0;
      i_part_nxt = PART_0;
    end else if (i_part_r == PART_2) begin
      i_ch_nxt   = (i_ch_r == ICH_END) ? i_ch_r : i_ch_r + ICH_W'(1);
      i_part_nxt = PART_0;
    end else begin
      i_ch_nxt   = i_ch_r;
      i_part_nxt = i_part_r + part_t'(1);
    end
  end

  assign accepted_nxt = in_first_byte ? len_ok : (accepted_r && len_ok);
  assign active = accept && accepted_nxt;
  assign dat_in = (off_nxt >= HEADER_OFF) && (off_nxt < PACKET_LEN) && (d_blk_nxt < BLK_END);
  assign inf_in = (off_nxt >= VANG_OFF) && (i_ch_nxt < ICH_END);

  // Angle table write on the low byte of each entry
  assign ang_mag   = {high_hold_r, in_pkt_byte};
  assign tab_we    = active && in_func && inf_in && (i_part_nxt == PART_2);
  assign tab_wdata = (sign_hold_r == SIGN_NEG_BYTE) ? -{1'b0, ang_mag} : {1'b0, ang_mag};

  // Azimuth delta with wrap and saturation of the running sum
  assign az_new = {block_az_r[15:8], in_pkt_byte};
  always_comb begin
    delta = $signed({2'b00, az_new}) - $signed({2'b00, prev_az_r});
    if (az_new < prev_az_r) begin
      delta = delta + FULL_TURN;
    end
    sum_ext = $signed({2'b00, angle_sum_r}) + {{4{delta[17]}}, delta};
  end

  assign emit = active && !in_func && dat_in && (d_pos_nxt >= POS_POINTS)
                && (d_part_nxt == PART_2) && flag_ok_r && table_valid_r;

  always_comb begin
    pt_new.azimuth   = block_az_r;
    pt_new.channel   = d_ch_nxt;
    pt_new.distance  = dist_hold_r & DIST_MASK;
    pt_new.intensity = in_pkt_byte;
    pt_new.seconds   = time_sec_r;
    pt_new.micros    = time_us_r;
    pt_new.frame_end = (d_ch_nxt == CH_LAST) && (angle_sum_r >= TURN_SUM);
  end

  always_comb begin
    table_valid_nxt = table_valid_r;
    sign_hold_nxt   = sign_hold_r;
    high_hold_nxt   = high_hold_r;
    time_sec_nxt    = time_sec_r;
    time_us_nxt     = time_us_r;
    flag_ok_nxt     = flag_ok_r;
    block_az_nxt    = block_az_r;
    dist_hold_nxt   = dist_hold_r;
    collecting_nxt  = collecting_r;
    angle_sum_nxt   = angle_sum_r;
    prev_az_nxt     = prev_az_r;

    if (active && in_func && inf_in) begin
      case (i_part_nxt)
        PART_0: sign_hold_nxt = in_pkt_byte;
        PART_1: high_hold_nxt = in_pkt_byte;
        PART_2: begin
          if (i_ch_nxt == ICH_LAST) begin
            table_valid_nxt = 1'b1;
          end
        end
        default: ;
      endcase
    end

    if (active && !in_func) begin
      if (off_nxt >= SEC_OFF && off_nxt < MICRO_OFF) begin
        time_sec_nxt = (off_nxt == SEC_OFF) ? {40'd0, in_pkt_byte}
                                            : {time_sec_r[39:0], in_pkt_byte};
      end else if (off_nxt >= MICRO_OFF && off_nxt < MICRO_END) begin
        time_us_nxt = (off_nxt == MICRO_OFF) ? {24'd0, in_pkt_byte}
                                             : {time_us_r[23:0], in_pkt_byte};
      end else if (dat_in) begin
        if (d_pos_nxt == POS_FLAG_HI) begin
          flag_ok_nxt = (in_pkt_byte == FLAG_HI_BYTE);
        end else if (d_pos_nxt == POS_FLAG_LO) begin
          flag_ok_nxt = flag_ok_r && (in_pkt_byte == FLAG_LO_BYTE);
        end else if (d_pos_nxt == POS_AZ_HI) begin
          block_az_nxt = {in_pkt_byte, 8'h00};
        end else if (d_pos_nxt == POS_AZ_LO) begin
          block_az_nxt = az_new;
          if (flag_ok_r && table_valid_r) begin
            // first block of a turn starts the sum without a delta
            if (!collecting_r) begin
              collecting_nxt = 1'b1;
              angle_sum_nxt  = '0;
            end else if (sum_ext[21]) begin
              angle_sum_nxt = '0;
            end else if (sum_ext > $signed({2'b00, SUM_MAX})) begin
              angle_sum_nxt = SUM_MAX;
            end else begin
              angle_sum_nxt = sum_ext[SUM_W-1:0];
            end
            prev_az_nxt = az_new;
          end
        end else begin
          case (d_part_nxt)
            PART_0: dist_hold_nxt = {in_pkt_byte[6:0], 8'h00};
            PART_1: dist_hold_nxt = {dist_hold_r[14:8], in_pkt_byte};
            PART_2: begin
              if (emit && pt_new.frame_end) begin
                collecting_nxt = 1'b0;
                angle_sum_nxt  = '0;
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

  always_comb begin
    if (emit) begin
      s1_valid_nxt = 1'b1;
    end else if (move) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end

    if (move) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Read data stays put until the next point enters the read stage
  lppd_ram #(
    .WIDTH (ANG_W),
    .DEPTH (CHANNELS)
  ) u_angle_ram (
    .clk   (clk),
    .we    (tab_we),
    .waddr (i_ch_nxt[TAB_AW-1:0]),
    .wdata (tab_wdata),
    .re    (emit),
    .raddr (d_ch_nxt[TAB_AW-1:0]),
    .rdata (tab_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r         <= '0;
      d_pos_r       <= '0;
      d_blk_r       <= '0;
      d_ch_r        <= '0;
      d_part_r      <= PART_0;
      i_ch_r        <= '0;
      i_part_r      <= PART_0;
      accepted_r    <= 1'b0;
      table_valid_r <= 1'b0;
      sign_hold_r   <= '0;
      high_hold_r   <= '0;
      time_sec_r    <= '0;
      time_us_r     <= '0;
      flag_ok_r     <= 1'b0;
      block_az_r    <= '0;
      dist_hold_r   <= '0;
      collecting_r  <= 1'b0;
      angle_sum_r   <= '0;
      prev_az_r     <= '0;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (accept) begin
        off_r      <= off_nxt;
        d_pos_r    <= d_pos_nxt;
        d_blk_r    <= d_blk_nxt;
        d_ch_r     <= d_ch_nxt;
        d_part_r   <= d_part_nxt;
        i_ch_r     <= i_ch_nxt;
        i_part_r   <= i_part_nxt;
        accepted_r <= accepted_nxt;
      end
      table_valid_r <= table_valid_nxt;
      sign_hold_r   <= sign_hold_nxt;
      high_hold_r   <= high_hold_nxt;
      time_sec_r    <= time_sec_nxt;
      time_us_r     <= time_us_nxt;
      flag_ok_r     <= flag_ok_nxt;
      block_az_r    <= block_az_nxt;
      dist_hold_r   <= dist_hold_nxt;
      collecting_r  <= collecting_nxt;
      angle_sum_r   <= angle_sum_nxt;
      prev_az_r     <= prev_az_nxt;
      s1_valid_r    <= s1_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      s1_pt_r <= pt_new;
    end
    if (move) begin
      out_pt_r    <= s1_pt_r;
      out_angle_r <= tab_rdata;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_azimuth        = out_pt_r.azimuth;
  assign out_channel        = out_pt_r.channel;
  assign out_distance_raw   = out_pt_r.distance;
  assign out_intensity      = out_pt_r.intensity;
  assign out_vertical_angle = $signed(out_angle_r);
  assign out_stamp_seconds  = out_pt_r.seconds;
  assign out_stamp_micros   = out_pt_r.micros;
  assign out_frame_end      = out_pt_r.frame_end;

endmodule

// ----- tb/lidar_packet_point_decoder_core_tb.sv -----
`timescale 1ns / 1ps
// Testbench for the lidar packet point decoder: datagram streams in, decoded points checked.
module lidar_packet_point_decoder_core_tb;
  import lppd_pkg::*;

  localparam int BLOCK_BYTES      = 4 + 3 * CHANNELS;
  localparam int TABLE_END        = int'(VANG_OFF) + 3 * CHANNELS;
  localparam int BODY_END         = int'(HEADER_OFF) + BLOCKS * BLOCK_BYTES;
  localparam int QUIET_LIMIT      = 2000;
  localparam int IDLE_PCT         = 34;
  localparam int PRINT_MAX        = 40;
  localparam int RANDOM_DATAGRAMS = 10;

  typedef struct packed {
    logic [15:0]      az;
    logic [CH_W-1:0]  ch;
    logic [14:0]      dist_raw;
    logic [7:0]       inten;
    logic [ANG_W-1:0] vang;
    logic [47:0]      sec;
    logic [31:0]      usec;
    logic             fend;
  } point_t;

  typedef struct packed {
    logic             func;
    logic [7:0]       data;
    logic [OFF_W-1:0] len;
    logic             first;
  } byte_req_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    in_func = 1'b0;
  logic [7:0]              in_pkt_byte = '0;
  logic [OFF_W-1:0]        in_pkt_len = '0;
  logic                    in_first_byte = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [15:0]             out_azimuth;
  logic [CH_W-1:0]         out_channel;
  logic [14:0]             out_distance_raw;
  logic [7:0]              out_intensity;
  logic signed [ANG_W-1:0] out_vertical_angle;
  logic [47:0]             out_stamp_seconds;
  logic [31:0]             out_stamp_micros;
  logic                    out_frame_end;

  lidar_packet_point_decoder_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_pkt_byte       (in_pkt_byte),
    .in_pkt_len        (in_pkt_len),
    .in_first_byte     (in_first_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_azimuth       (out_azimuth),
    .out_channel       (out_channel),
    .out_distance_raw  (out_distance_raw),
    .out_intensity     (out_intensity),
    .out_vertical_angle(out_vertical_angle),
    .out_stamp_seconds (out_stamp_seconds),
    .out_stamp_micros  (out_stamp_micros),
    .out_frame_end     (out_frame_end)
  );

  // Decoder state as predicted from the accepted bytes
  logic [OFF_W-1:0]        p_off = '0;
  logic                    p_acc = 1'b0;
  logic signed [ANG_W-1:0] p_angle [CHANNELS];
  logic                    p_tvalid = 1'b0;
  logic [7:0]              p_sign = '0;
  logic [7:0]              p_high = '0;
  logic [47:0]             p_sec = '0;
  logic [31:0]             p_usec = '0;
  logic                    p_flag = 1'b0;
  logic [15:0]             p_az = '0;
  logic [14:0]             p_dist = '0;
  logic                    p_collect = 1'b0;
  int                      p_sum = 0;
  logic [15:0]             p_prev = '0;

  point_t    expected_points[$];
  byte_req_t burst[$];
  logic [15:0] blk_az [BLOCKS];
  logic      calm = 1'b0;
  int        mismatches = 0;
  int        quiet_cycles = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic void decode_expected(byte_req_t r);
    logic             ok;
    int               off, rel, blk, pos, idx, part, d, s;
    logic [ANG_W-1:0] mag;
    point_t           pt;
    ok = r.func ? (r.len >= INFO_MINLEN) : (r.len == PACKET_LEN);
    if (r.first) begin
      p_off = '0;
      p_acc = ok;
    end else begin
      if (p_off != OFF_MAX) p_off = p_off + 1'b1;
      p_acc = p_acc && ok;
    end
    if (!p_acc) return;
    off = int'(p_off);
    if (r.func) begin
      if (off >= int'(VANG_OFF) && off < TABLE_END) begin
        rel = off - int'(VANG_OFF);
        idx = rel / 3;
        part = rel % 3;
        if (part == int'(PART_0)) begin
          p_sign = r.data;
        end else if (part == int'(PART_1)) begin
          p_high = r.data;
        end else begin
          mag = {1'b0, p_high, r.data};
          p_angle[idx] = (p_sign == SIGN_NEG_BYTE) ? -mag : mag;
          if (idx == CHANNELS - 1) p_tvalid = 1'b1;
        end
      end
      return;
    end
    if (off >= int'(SEC_OFF) && off < int'(MICRO_OFF)) begin
      p_sec = (off == int'(SEC_OFF)) ? 48'(r.data) : {p_sec[39:0], r.data};
      return;
    end
    if (off >= int'(MICRO_OFF) && off < int'(MICRO_END)) begin
      p_usec = (off == int'(MICRO_OFF)) ? 32'(r.data) : {p_usec[23:0], r.data};
      return;
    end
    if (off < int'(HEADER_OFF) || off >= PACKET_BYTES) return;
    rel = off - int'(HEADER_OFF);
    blk = rel / BLOCK_BYTES;
    pos = rel % BLOCK_BYTES;
    if (blk >= BLOCKS) return;
    if (pos == int'(POS_FLAG_HI)) begin
      p_flag = (r.data == FLAG_HI_BYTE);
    end else if (pos == int'(POS_FLAG_LO)) begin
      p_flag = p_flag && (r.data == FLAG_LO_BYTE);
    end else if (pos == int'(POS_AZ_HI)) begin
      p_az = {r.data, 8'h00};
    end else if (pos == int'(POS_AZ_LO)) begin
      p_az[7:0] = r.data;
      if (p_flag && p_tvalid) begin
        if (!p_collect) begin
          // first good block of a frame: start from zero, no delta
          p_collect = 1'b1;
          p_sum = 0;
        end else begin
          d = int'(p_az) - int'(p_prev);
          if (d < 0) d += int'(FULL_TURN);
          s = p_sum + d;
          if (s < 0) s = 0;
          if (s > int'(SUM_MAX)) s = int'(SUM_MAX);
          p_sum = s;
        end
        p_prev = p_az;
      end
    end else begin
      idx = (pos - int'(POS_POINTS)) / 3;
      part = (pos - int'(POS_POINTS)) % 3;
      if (part == int'(PART_0)) begin
        p_dist = {r.data[6:0], 8'h00};
      end else if (part == int'(PART_1)) begin
        p_dist[7:0] = r.data;
      end else if (p_flag && p_tvalid) begin
        pt.az = p_az;
        pt.ch = CH_W'(idx);
        pt.dist_raw = p_dist;
        pt.inten = r.data;
        pt.vang = p_angle[idx];
        pt.sec = p_sec;
        pt.usec = p_usec;
        pt.fend = (idx == CHANNELS - 1) && (p_sum >= int'(TURN_SUM));
        if (pt.fend) begin
          p_collect = 1'b0;
          p_sum = 0;
        end
        expected_points.push_back(pt);
      end
    end
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    if (mismatches < PRINT_MAX)
      $display("mismatch at %0t: %s got %0h want %0h", $realtime, field, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : point_check
    point_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_points.size() == 0) begin
        report_mismatch("point with nothing pending, channel", out_channel, 0);
      end else begin
        want = expected_points.pop_front();
        if (out_azimuth !== want.az) report_mismatch("azimuth", out_azimuth, want.az);
        if (out_channel !== want.ch) report_mismatch("channel", out_channel, want.ch);
        if (out_distance_raw !== want.dist_raw)
          report_mismatch("distance_raw", out_distance_raw, want.dist_raw);
        if (out_intensity !== want.inten)
          report_mismatch("intensity", out_intensity, want.inten);
        if ({out_vertical_angle} !== want.vang)
          report_mismatch("vertical_angle", {out_vertical_angle}, want.vang);
        if (out_stamp_seconds !== want.sec)
          report_mismatch("stamp_seconds", out_stamp_seconds, want.sec);
        if (out_stamp_micros !== want.usec)
          report_mismatch("stamp_micros", out_stamp_micros, want.usec);
        if (out_frame_end !== want.fend)
          report_mismatch("frame_end", out_frame_end, want.fend);
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // End the run when no request moves on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send_req(byte_req_t r);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= r.func;
    in_pkt_byte <= r.data;
    in_pkt_len <= r.len;
    in_first_byte <= r.first;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_expected(r);
  endtask

  // Drop valid and hold until every pending point has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_points.size() != 0) @(posedge clk);
  endtask

  task automatic send_burst(int pause_at);
    foreach (burst[i]) begin
      if (i == pause_at) wait_drained();
      send_req(burst[i]);
    end
    burst.delete();
  endtask

  function automatic void push_byte(logic func, logic [7:0] data, int len, logic first);
    byte_req_t r;
    r.func = func;
    r.data = data;
    r.len = OFF_W'(len);
    r.first = first;
    burst.push_back(r);
  endfunction

  function automatic void set_azimuths(int start, int step, int modulus);
    for (int k = 0; k < BLOCKS; k++) blk_az[k] = 16'((start + k * step) % modulus);
  endfunction

  function automatic void build_info(int len, int nbytes, logic extremes);
    logic [7:0]  b, sgn;
    logic [15:0] mag;
    int          rel;
    for (int i = 0; i < nbytes; i++) begin
      b = 8'($urandom);
      if (i >= int'(VANG_OFF) && i < TABLE_END) begin
        rel = i - int'(VANG_OFF);
        if (extremes) begin
          case ((rel / 3) % 4)
            0: begin sgn = 8'h00;         mag = 16'hFFFF; end
            1: begin sgn = SIGN_NEG_BYTE; mag = 16'hFFFF; end
            2: begin sgn = SIGN_NEG_BYTE; mag = 16'h0000; end
            default: begin sgn = 8'hFF;   mag = 16'h8000; end
          endcase
          b = (rel % 3 == 0) ? sgn : (rel % 3 == 1) ? mag[15:8] : mag[7:0];
        end else if (rel % 3 == 0 && $urandom_range(1) == 1) begin
          b = SIGN_NEG_BYTE;
        end
      end
      push_byte(1'b1, b, len, i == 0);
    end
  endfunction

  function automatic void build_data(int nbytes, int len, logic [47:0] sec, logic [31:0] usec,
                                     logic [7:0] bad_mask, logic extremes);
    logic [7:0] b;
    int         rel, blk, pos;
    for (int i = 0; i < nbytes; i++) begin
      b = 8'($urandom);
      if (i >= int'(SEC_OFF) && i < int'(MICRO_OFF)) begin
        b = sec[8 * (int'(MICRO_OFF) - 1 - i) +: 8];
      end else if (i >= int'(MICRO_OFF) && i < int'(MICRO_END)) begin
        b = usec[8 * (int'(MICRO_END) - 1 - i) +: 8];
      end else if (i >= int'(HEADER_OFF) && i < BODY_END) begin
        rel = i - int'(HEADER_OFF);
        blk = rel / BLOCK_BYTES;
        pos = rel % BLOCK_BYTES;
        // bad blocks break the flag in one of three ways, by block number
        if (pos == int'(POS_FLAG_HI)) begin
          b = !bad_mask[blk] ? FLAG_HI_BYTE : (blk % 3 == 0) ? 8'h00 :
              (blk % 3 == 2) ? FLAG_LO_BYTE : FLAG_HI_BYTE;
        end else if (pos == int'(POS_FLAG_LO)) begin
          b = !bad_mask[blk] ? FLAG_LO_BYTE : (blk % 3 == 1) ? 8'h00 :
              (blk % 3 == 2) ? FLAG_HI_BYTE : FLAG_LO_BYTE;
        end else if (pos == int'(POS_AZ_HI)) begin
          b = blk_az[blk][15:8];
        end else if (pos == int'(POS_AZ_LO)) begin
          b = blk_az[blk][7:0];
        end else if (extremes) begin
          b = (((pos - int'(POS_POINTS)) / 3 + blk) % 2 == 1) ? 8'hFF : 8'h00;
        end
      end
      push_byte(1'b0, b, len, i == 0);
    end
  endfunction

  function automatic void build_noise();
    logic func;
    int   len;
    for (int i = $urandom_range(5, 60); i > 0; i--) begin
      func = 1'($urandom_range(1));
      len = ($urandom_range(2) != 0) ? $urandom_range(2047) :
            func ? $urandom_range(1044, 2047) : PACKET_BYTES;
      push_byte(func, 8'($urandom), len, $urandom_range(9) == 0);
    end
  endfunction

  function automatic logic [47:0] rand_sec();
    return 48'({$urandom, $urandom});
  endfunction

  task automatic test_before_table();
    // stray bytes with no first byte after reset are ignored
    for (int i = 0; i < 5; i++)
      push_byte(1'($urandom_range(1)), 8'($urandom), $urandom_range(2047), 1'b0);
    set_azimuths(1000, 9000, 36000);
    build_data(PACKET_BYTES, PACKET_BYTES, rand_sec(), $urandom, 8'h00, 1'b0);
    send_burst(-1);
  endtask

  task automatic test_rejected_info();
    build_info(1043, 1043, 1'b0);
    send_burst(-1);
    // truncated load: early entries written, table still not valid
    build_info(1044, 540, 1'b0);
    send_burst(-1);
    set_azimuths(0, 4000, 36000);
    build_data(PACKET_BYTES, PACKET_BYTES, rand_sec(), $urandom, 8'h00, 1'b0);
    send_burst(-1);
  endtask

  task automatic test_table_extremes();
    build_info(1044, 1044, 1'b1);
    send_burst(-1);
    calm = 1'b1;
    blk_az = '{16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd36000, 16'd35999, 16'd0, 16'd1};
    build_data(PACKET_BYTES, PACKET_BYTES, '1, '0, 8'h00, 1'b1);
    send_burst(-1);
    build_data(PACKET_BYTES, PACKET_BYTES, '0, '1, 8'h00, 1'b1);
    send_burst(-1);
    wait_drained();
    calm = 1'b0;
  endtask

  task automatic test_block_flags();
    set_azimuths(100, 4500, 36000);
    build_data(PACKET_BYTES, PACKET_BYTES, rand_sec(), $urandom, 8'b1011_0110, 1'b0);
    send_burst(-1);
  endtask

  task automatic test_lengths();
    byte_req_t r;
    set_azimuths(200, 7000, 36000);
    build_data(PACKET_BYTES, PACKET_BYTES - 1, rand_sec(), $urandom, 8'h00, 1'b0);
    send_burst(-1);
    build_data(PACKET_BYTES, PACKET_BYTES + 1, rand_sec(), $urandom, 8'h00, 1'b0);
    send_burst(-1);
    // a wrong length mid-datagram drops the rest of it
    build_data(PACKET_BYTES, PACKET_BYTES, rand_sec(), $urandom, 8'h00, 1'b0);
    r = burst[700];
    r.len = OFF_W'(PACKET_BYTES - 1);
    burst[700] = r;
    send_burst(-1);
    build_info(2047, 2047, 1'b0);
    send_burst(-1);
    // overlong datagram: offset saturates
    build_data(2100, PACKET_BYTES, rand_sec(), $urandom, 8'h00, 1'b0);
    send_burst(-1);
  endtask

  task automatic test_mixed_tags();
    byte_req_t r;
    set_azimuths(5000, 3000, 36000);
    build_data(PACKET_BYTES, PACKET_BYTES, rand_sec(), $urandom, 8'h00, 1'b0);
    for (int i = 470; i < 481; i++) begin
      r = burst[i];
      r.func = 1'b1;
      burst[i] = r;
    end
    r = burst[100];
    r.func = 1'b1;
    burst[100] = r;
    send_burst(-1);
    // info datagram of data length: data-tagged bytes decode as data
    build_info(PACKET_BYTES, PACKET_BYTES, 1'b0);
    for (int i = 50; i < 61; i++) begin
      r = burst[i];
      r.func = 1'b0;
      burst[i] = r;
    end
    send_burst(-1);
    build_info(1100, 1100, 1'b0);
    r = burst[300];
    r.func = 1'b0;
    burst[300] = r;
    send_burst(-1);
  endtask

  task automatic test_azimuth_wrap();
    blk_az = '{16'd35000, 16'd65535, 16'd100, 16'd20000,
               16'd35999, 16'd100, 16'd100, 16'd18100};
    build_data(PACKET_BYTES, PACKET_BYTES, rand_sec(), $urandom, 8'h00, 1'b0);
    send_burst(600);
    blk_az = '{16'd0, 16'd36000, 16'd1000, 16'd1000, 16'd60000, 16'd30000, 16'd5000, 16'd5000};
    build_data(PACKET_BYTES, PACKET_BYTES, rand_sec(), $urandom, 8'h00, 1'b0);
    send_burst(-1);
    set_azimuths(0, 18000, 36000);
    build_data(PACKET_BYTES, PACKET_BYTES, rand_sec(), $urandom, 8'h00, 1'b0);
    send_burst(-1);
  endtask

  task automatic test_random();
    int        kind, j;
    byte_req_t r;
    for (int n = 0; n < RANDOM_DATAGRAMS; n++) begin
      kind = $urandom_range(99);
      set_azimuths($urandom_range(35999),
                   ($urandom_range(1) == 1) ? $urandom_range(20000) : $urandom_range(1500),
                   ($urandom_range(4) == 0) ? 65536 : 36000);
      if (kind < 55) begin
        build_data(PACKET_BYTES, PACKET_BYTES, rand_sec(), $urandom,
                   ($urandom_range(4) == 0) ? 8'($urandom) : 8'h00, 1'b0);
      end else if (kind < 65) begin
        j = ($urandom_range(5) == 0) ? 2047 : $urandom_range(1044, 1300);
        build_info(j, j, 1'b0);
      end else if (kind < 75) begin
        // broken datagram: stray tags or lengths
        build_data(PACKET_BYTES, PACKET_BYTES, rand_sec(), $urandom, 8'h00, 1'b0);
        repeat ($urandom_range(1, 6)) begin
          j = $urandom_range(burst.size() - 1);
          r = burst[j];
          if ($urandom_range(1) == 1) r.func = 1'b1;
          else r.len = OFF_W'($urandom_range(2047));
          burst[j] = r;
        end
      end else if (kind < 85) begin
        build_data($urandom_range(50, 1200), PACKET_BYTES, rand_sec(), $urandom, 8'h00, 1'b0);
      end else begin
        build_noise();
      end
      send_burst((kind < 55 && $urandom_range(3) == 0) ? $urandom_range(100, 1200) : -1);
      if ($urandom_range(4) == 0) wait_drained();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_before_table();
    test_rejected_info();
    test_table_extremes();
    test_block_flags();
    test_lengths();
    test_mixed_tags();
    test_azimuth_wrap();
    test_random();
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
